### rtl/dbca_pkg.sv
// shared constants, types and codes of the buffer cache with frame aging
package dbca_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int SLOT_BYTES = 4096;
    localparam int IDX_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

    localparam logic [7:0] REUSE_RESET = 8'd14;
    localparam logic       REG_REUSE   = 1'b0;

    // transaction kinds on the action field
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // one entry of the used list
    typedef struct packed {
        logic [31:0]      start;
        logic [31:0]      last;
        logic [IDX_W-1:0] slot;
    } t_entry;

    // per-cell operation, shared by used-list and free-list cells
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_SHR,
        CELL_LOAD,
        CELL_TOUCH
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC,
        ST_UPD,
        ST_TICK
    } t_state;

endpackage

### rtl/dbca_used_cell.sv
// one cell of the used-buffer list: holds an entry and its compare flags
module dbca_used_cell import dbca_pkg::*; (
    input  logic        i_clk,
    input  t_cell_op    i_op,
    input  t_entry      i_left,
    input  t_entry      i_right,
    input  t_entry      i_new,
    input  logic [31:0] i_frame,
    input  logic [31:0] i_addr,
    input  logic [12:0] i_len,
    output t_entry      o_entry,
    output logic        o_gt,
    output logic        o_cov
);

    t_entry r_entry, n_entry;
    logic   r_gt, r_cov;
    logic [32:0] w_end, w_lim;

    // entry update from neighbours or new data
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_SHL:   n_entry = i_right;
            CELL_SHR:   n_entry = i_left;
            CELL_LOAD:  n_entry = i_new;
            CELL_TOUCH: n_entry.last = i_frame;
            default:    n_entry = r_entry;
        endcase
    end

    // range compare against the latched lookup
    assign w_end = {1'b0, i_addr} + {20'd0, i_len};
    assign w_lim = {1'b0, r_entry.start} + 33'(SLOT_BYTES);

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_gt    <= (r_entry.start > i_addr);
        r_cov   <= (w_end <= w_lim);
    end

    assign o_entry = r_entry;
    assign o_gt    = r_gt;
    assign o_cov   = r_cov;

endmodule

### rtl/dbca_free_cell.sv
// one cell of the free-slot list
module dbca_free_cell import dbca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_init,
    input  t_cell_op         i_op,
    input  logic [IDX_W-1:0] i_left,
    input  logic [IDX_W-1:0] i_right,
    input  logic [IDX_W-1:0] i_new,
    output logic [IDX_W-1:0] o_slot
);

    logic [IDX_W-1:0] r_slot, n_slot;

    // shift, insert or hold
    always_comb begin
        case (i_op)
            CELL_SHL:  n_slot = i_right;
            CELL_SHR:  n_slot = i_left;
            CELL_LOAD: n_slot = i_new;
            default:   n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= i_init;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

### rtl/dma_buffer_cache_with_aging_core.sv
// top level: control sequencer, register port and the two cell chains
//
// A lookup (action 0) goes from start to the result strobe in order: the
// request is latched, every used-list cell compares its range, the first match
// and the insert position are picked, and the chain is updated. A frame tick
// (action 1) walks the used list one entry a cycle from its head, each entry
// being released or rotated back in. The result appears for one cycle on o_done
// and cannot be held off; busy is high from the accepting edge until the cycle
// the result is shown.
module dma_buffer_cache_with_aging_core import dbca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_address,
    input  logic [12:0] i_length,
    output logic        o_done,
    output logic        o_hit,
    output logic [4:0]  o_slot,
    output logic [11:0] o_offset,
    output logic        o_dma_request,
    output logic [31:0] o_dma_address,
    output logic        o_no_buffer,
    output logic [5:0]  o_released_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;
    logic [7:0]       r_reuse;
    logic [31:0]      r_addr, r_frame;
    logic [12:0]      r_len;
    logic [CNT_W-1:0] r_used_cnt, r_free_cnt, r_iter, r_tick_n, r_pos;
    logic [CNT_W-1:0] r_rel;
    logic             r_hit;
    logic [IDX_W-1:0] r_hidx;

    logic             r_done, r_o_hit, r_o_dreq, r_o_nobuf;
    logic [4:0]       r_o_slot;
    logic [11:0]      r_o_offset;
    logic [31:0]      r_o_daddr;
    logic [5:0]       r_o_rel;

    t_entry           w_ent [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_gt, w_cov;
    logic [IDX_W-1:0] w_fslot [NUM_SLOTS];
    t_cell_op         w_uop [NUM_SLOTS];
    t_cell_op         w_fop [NUM_SLOTS];
    t_entry           w_new;

    logic [NUM_SLOTS-1:0] w_vmask, w_gtm, w_below, w_hv;
    logic [CNT_W-1:0] w_stop;
    logic [IDX_W-1:0] w_hidx;
    logic             w_hany;

    logic             w_acc, w_cfg_wr, w_keep, w_rel_now, w_full, w_tick_end;
    logic             w_ins, w_push;
    logic [31:0]      w_limit;
    logic [CNT_W-1:0] w_cm1;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_REUSE) ? {24'd0, r_reuse} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reuse <= REUSE_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_REUSE) begin
            r_reuse <= pwdata[7:0];
        end
    end

    assign busy  = (r_state != ST_IDLE);
    assign w_acc = start && !busy;

    // aging test on the head entry during a tick
    assign w_limit    = w_ent[0].last + {24'd0, r_reuse};
    assign w_rel_now  = (w_limit < r_frame);
    assign w_tick_end = (r_iter == r_tick_n);
    assign w_keep     = (r_state == ST_TICK) && !w_tick_end && !w_rel_now;
    assign w_cm1      = r_used_cnt - 1'b1;
    assign w_full     = (r_free_cnt == '0) || (r_used_cnt >= CNT_W'(NUM_SLOTS));
    assign w_ins      = (r_state == ST_UPD) && !r_hit && !w_full;
    assign w_push     = (r_state == ST_TICK) && !w_tick_end && w_rel_now;

    // first match and insert position from the registered cell flags
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_vmask[i] = (CNT_W'(i) < r_used_cnt);
        end
        w_gtm   = w_gt & w_vmask;
        w_below = (w_gtm & (~w_gtm + 1'b1)) - 1'b1;
        w_hv    = w_cov & w_vmask & w_below;
        w_stop  = r_used_cnt;
        w_hidx  = '0;
        w_hany  = |w_hv;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (w_gtm[i]) w_stop = CNT_W'(i);
            if (w_hv[i])  w_hidx = IDX_W'(i);
        end
    end

    // new entry for a miss insert, or the head rotated back during a tick
    always_comb begin
        if (r_state == ST_TICK) begin
            w_new = w_ent[0];
        end else begin
            w_new.start = {r_addr[31:1], 1'b0};
            w_new.last  = r_frame;
            w_new.slot  = w_fslot[0];
        end
    end

    // per-cell operations of the used chain
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_uop[k] = CELL_HOLD;
            if (r_state == ST_UPD) begin
                if (r_hit && r_hidx == IDX_W'(k)) begin
                    w_uop[k] = CELL_TOUCH;
                end else if (w_ins && CNT_W'(k) == r_pos) begin
                    w_uop[k] = CELL_LOAD;
                end else if (w_ins && CNT_W'(k) > r_pos && CNT_W'(k) <= r_used_cnt) begin
                    w_uop[k] = CELL_SHR;
                end
            end else if (r_state == ST_TICK && !w_tick_end) begin
                w_uop[k] = (w_keep && CNT_W'(k) == w_cm1) ? CELL_LOAD : CELL_SHL;
            end
        end
    end

    // per-cell operations of the free chain
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_fop[k] = CELL_HOLD;
            if (w_ins) begin
                w_fop[k] = CELL_SHL;
            end else if (w_push && r_free_cnt < CNT_W'(NUM_SLOTS)) begin
                if (r_free_cnt == '0) begin
                    if (k == 0) w_fop[k] = CELL_LOAD;
                end else if (k == 1) begin
                    w_fop[k] = CELL_LOAD;
                end else if (k >= 2 && CNT_W'(k) <= r_free_cnt) begin
                    w_fop[k] = CELL_SHR;
                end
            end
        end
    end

    // cell chains
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == NUM_SLOTS - 1) ? g : g + 1;

        dbca_used_cell u_used (
            .i_clk   (i_clk),
            .i_op    (w_uop[g]),
            .i_left  (w_ent[L]),
            .i_right (w_ent[R]),
            .i_new   (w_new),
            .i_frame (r_frame),
            .i_addr  (r_addr),
            .i_len   (r_len),
            .o_entry (w_ent[g]),
            .o_gt    (w_gt[g]),
            .o_cov   (w_cov[g])
        );

        dbca_free_cell u_free (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  (IDX_W'(g)),
            .i_op    (w_fop[g]),
            .i_left  (w_fslot[L]),
            .i_right (w_fslot[R]),
            .i_new   (w_ent[0].slot),
            .o_slot  (w_fslot[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_acc) n_state = (i_action == ACT_TICK) ? ST_TICK : ST_CMP;
            ST_CMP:  n_state = ST_DEC;
            ST_DEC:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            ST_TICK: if (w_tick_end) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used_cnt <= '0;
            r_free_cnt <= CNT_W'(NUM_SLOTS);
            r_frame    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == ST_UPD) || (r_state == ST_TICK && w_tick_end));
            if (w_ins) begin
                r_used_cnt <= r_used_cnt + 1'b1;
                r_free_cnt <= r_free_cnt - 1'b1;
            end
            if (w_push) begin
                r_used_cnt <= r_used_cnt - 1'b1;
                if (r_free_cnt < CNT_W'(NUM_SLOTS)) r_free_cnt <= r_free_cnt + 1'b1;
            end
            if (r_state == ST_TICK && w_tick_end) r_frame <= r_frame + 1'b1;
        end
    end

    // transaction data and results
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_addr   <= i_address;
            r_len    <= i_length;
            r_iter   <= '0;
            r_tick_n <= r_used_cnt;
            r_rel    <= '0;
        end
        if (r_state == ST_DEC) begin
            r_hit  <= w_hany;
            r_hidx <= w_hidx;
            r_pos  <= w_stop;
        end
        if (r_state == ST_TICK && !w_tick_end) begin
            r_iter <= r_iter + 1'b1;
            if (w_rel_now) r_rel <= r_rel + 1'b1;
        end
        if (r_state == ST_UPD) begin
            r_o_rel <= '0;
            if (r_hit) begin
                r_o_hit    <= 1'b1;
                r_o_slot   <= 5'(w_ent[r_hidx].slot);
                r_o_offset <= 12'(r_addr - w_ent[r_hidx].start);
                r_o_dreq   <= 1'b0;
                r_o_daddr  <= '0;
                r_o_nobuf  <= 1'b0;
            end else if (w_full) begin
                r_o_hit    <= 1'b0;
                r_o_slot   <= '0;
                r_o_offset <= '0;
                r_o_dreq   <= 1'b0;
                r_o_daddr  <= '0;
                r_o_nobuf  <= 1'b1;
            end else begin
                r_o_hit    <= 1'b0;
                r_o_slot   <= 5'(w_fslot[0]);
                r_o_offset <= {11'd0, r_addr[0]};
                r_o_dreq   <= 1'b1;
                r_o_daddr  <= {r_addr[31:1], 1'b0};
                r_o_nobuf  <= 1'b0;
            end
        end else if (r_state == ST_TICK && w_tick_end) begin
            r_o_hit    <= 1'b0;
            r_o_slot   <= '0;
            r_o_offset <= '0;
            r_o_dreq   <= 1'b0;
            r_o_daddr  <= '0;
            r_o_nobuf  <= 1'b0;
            r_o_rel    <= 6'(r_rel);
        end
    end

    assign o_done           = r_done;
    assign o_hit            = r_o_hit;
    assign o_slot           = r_o_slot;
    assign o_offset         = r_o_offset;
    assign o_dma_request    = r_o_dreq;
    assign o_dma_address    = r_o_daddr;
    assign o_no_buffer      = r_o_nobuf;
    assign o_released_count = r_o_rel;

endmodule

### tb/tb_dma_buffer_cache_with_aging_core.sv
// testbench for the buffer cache with frame aging: directed and random lookups and ticks
`timescale 1ns / 100ps

module tb_dma_buffer_cache_with_aging_core import dbca_pkg::*; ();

    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   RANDOM_ITEMS   = 950;

    typedef struct packed {
        bit        hit;
        bit [4:0]  slot;
        bit [11:0] offset;
        bit        dma_request;
        bit [31:0] dma_address;
        bit        no_buffer;
        bit [5:0]  released_count;
    } t_cache_result;

    // predicted cache state and queue of outstanding results
    class cache_scoreboard;
        bit [31:0]     buf_start[NUM_SLOTS];
        bit [31:0]     buf_frame[NUM_SLOTS];
        bit [4:0]      buf_slot[NUM_SLOTS];
        int            used_n;
        bit [4:0]      free_list[NUM_SLOTS];
        int            free_n;
        bit [31:0]     frame_no;
        bit [7:0]      reuse_limit;
        t_cache_result pending[$];
        int            mismatches;

        function new();
            used_n = 0;
            free_n = NUM_SLOTS;
            for (int i = 0; i < NUM_SLOTS; i++) free_list[i] = 5'(i);
            frame_no = 0;
            reuse_limit = REUSE_RESET;
            mismatches = 0;
        endfunction

        // released slot goes just behind the free-list head, or to the head if the list is empty
        function void return_slot(bit [4:0] s);
            if (free_n >= NUM_SLOTS) return;
            if (free_n == 0) begin
                free_list[0] = s;
            end else begin
                for (int k = free_n; k > 1; k--) free_list[k] = free_list[k-1];
                free_list[1] = s;
            end
            free_n++;
        endfunction

        function void note_transaction(bit act, bit [31:0] addr, bit [12:0] len);
            t_cache_result r;
            bit [32:0]     addr_end;
            bit [31:0]     lim;
            bit [4:0]      s;
            int            wr;
            int            rel;
            int            pos;
            r = '0;
            if (act == ACT_TICK) begin
                // age out stale buffers, keeping list order
                wr = 0;
                rel = 0;
                for (int rd = 0; rd < used_n; rd++) begin
                    lim = buf_frame[rd] + 32'(reuse_limit);
                    if (lim < frame_no) begin
                        return_slot(buf_slot[rd]);
                        rel++;
                    end else begin
                        buf_start[wr] = buf_start[rd];
                        buf_frame[wr] = buf_frame[rd];
                        buf_slot[wr]  = buf_slot[rd];
                        wr++;
                    end
                end
                used_n = wr;
                frame_no = frame_no + 1;
                r.released_count = 6'(rel);
                pending.push_back(r);
                return;
            end
            addr_end = {1'b0, addr} + 33'(len);
            for (pos = 0; pos < used_n; pos++) begin
                if (buf_start[pos] > addr) break;
                if (addr_end <= {1'b0, buf_start[pos]} + 33'(SLOT_BYTES)) begin
                    buf_frame[pos] = frame_no;
                    r.hit    = 1'b1;
                    r.slot   = buf_slot[pos];
                    r.offset = 12'(addr - buf_start[pos]);
                    pending.push_back(r);
                    return;
                end
            end
            if (free_n == 0 || used_n >= NUM_SLOTS) begin
                r.no_buffer = 1'b1;
                pending.push_back(r);
                return;
            end
            // miss: take the free-list head and insert in sorted position
            s = free_list[0];
            for (int k = 0; k + 1 < free_n; k++) free_list[k] = free_list[k+1];
            free_n--;
            for (int k = used_n; k > pos; k--) begin
                buf_start[k] = buf_start[k-1];
                buf_frame[k] = buf_frame[k-1];
                buf_slot[k]  = buf_slot[k-1];
            end
            buf_start[pos] = {addr[31:1], 1'b0};
            buf_frame[pos] = frame_no;
            buf_slot[pos]  = s;
            used_n++;
            r.slot        = s;
            r.offset      = 12'(addr[0]);
            r.dma_request = 1'b1;
            r.dma_address = {addr[31:1], 1'b0};
            pending.push_back(r);
        endfunction

        function void check_result(t_cache_result got);
            t_cache_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: exp hit=%0d slot=%0d off=%0d req=%0d",
                             $realtime, want.hit, want.slot, want.offset,
                             want.dma_request);
                    $display("    exp da=%h nb=%0d rel=%0d",
                             want.dma_address, want.no_buffer, want.released_count);
                    $display("    act hit=%0d slot=%0d off=%0d req=%0d",
                             got.hit, got.slot, got.offset, got.dma_request);
                    $display("    act da=%h nb=%0d rel=%0d",
                             got.dma_address, got.no_buffer, got.released_count);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [31:0] i_address = '0;
    logic [12:0] i_length = '0;
    logic        o_done;
    logic        o_hit;
    logic [4:0]  o_slot;
    logic [11:0] o_offset;
    logic        o_dma_request;
    logic [31:0] o_dma_address;
    logic        o_no_buffer;
    logic [5:0]  o_released_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cache_scoreboard sb = new();
    int          idle_cycles = 0;
    int          gap_pct = 0;
    bit [31:0]   base_pool[16];

    dma_buffer_cache_with_aging_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_cache_result got;
        idle_cycles++;
        if (i_rst_n && o_done) begin
            got.hit = o_hit;
            got.slot = o_slot;
            got.offset = o_offset;
            got.dma_request = o_dma_request;
            got.dma_address = o_dma_address;
            got.no_buffer = o_no_buffer;
            got.released_count = o_released_count;
            sb.check_result(got);
            idle_cycles = 0;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(bit act, bit [31:0] addr, bit [12:0] len);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        @(negedge i_clk);
        i_action = act;
        i_address = addr;
        i_length = len;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_transaction(act, addr, len);
        idle_cycles = 0;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // hold off until every outstanding result is back and the block is quiet
    task automatic drain();
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reuse(bit [7:0] value);
        drain();
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_REUSE, 2'b00};
        pwdata = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.reuse_limit = value;
        idle_cycles = 0;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic bit [12:0] pick_length();
        case ($urandom_range(9))
            0:       return 13'd0;
            1:       return 13'd4096;
            2, 3:    return 13'($urandom_range(4096));
            default: return 13'($urandom_range(64));
        endcase
    endfunction

    task automatic random_segment(int n);
        bit [31:0] a;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            if ($urandom_range(7) == 0) begin
                send_item(ACT_TICK, $urandom, 13'($urandom));
            end else begin
                if ($urandom_range(9) == 0) a = $urandom;
                else a = base_pool[$urandom_range(15)] + $urandom_range(6000);
                if ($urandom_range(31) == 0) base_pool[$urandom_range(15)] = $urandom;
                send_item(ACT_LOOKUP, a, pick_length());
            end
        end
    endtask

    initial begin
        foreach (base_pool[i]) base_pool[i] = $urandom;
        base_pool[0] = 32'hFFFF_F000;
        base_pool[1] = 32'h0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: range edges, wide offset, top of address space
        send_item(ACT_LOOKUP, 32'h0, 13'd0);
        send_item(ACT_LOOKUP, 32'h0, 13'd4096);
        send_item(ACT_LOOKUP, 32'h1000, 13'd0);
        send_item(ACT_LOOKUP, 32'h1, 13'd4096);
        send_item(ACT_LOOKUP, 32'h1, 13'd4095);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 13'd4096);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 13'd1);
        send_item(ACT_LOOKUP, 32'h8000_0001, 13'd4096);
        send_item(ACT_LOOKUP, 32'h7FFF_FFFF, 13'd1);
        send_item(ACT_LOOKUP, 32'h5555_5555, 13'h0AAA);
        send_item(ACT_TICK, 32'hFFFF_FFFF, 13'h1FFF);
        // exhaust the free list, then age everything out
        write_reuse(8'd1);
        for (int i = 0; i < 30; i++) send_item(ACT_LOOKUP, 32'h10_0000 * (i + 1), 13'd16);
        for (int i = 0; i < 4; i++) send_item(ACT_TICK, 32'h0, 13'd0);
        write_reuse(8'd255);
        send_item(ACT_LOOKUP, 32'h2AAA_AAAA, 13'd8);

        // random: three idling phases under several reuse settings
        gap_pct = 32;
        random_segment(RANDOM_ITEMS / 4);
        write_reuse(8'd1);
        random_segment(RANDOM_ITEMS / 4);
        write_reuse(8'($urandom_range(2, 20)));
        gap_pct = 55;
        random_segment(RANDOM_ITEMS / 4);
        write_reuse(REUSE_RESET);
        gap_pct = 0;
        random_segment(RANDOM_ITEMS / 4);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
